// ===== rtl/polyline_ribbon_expander_defines.svh =====
// assertion macros for the polyline ribbon expander checker
`ifndef POLYLINE_RIBBON_EXPANDER_DEFINES_SVH
`define POLYLINE_RIBBON_EXPANDER_DEFINES_SVH

// property that holds at every edge outside reset
`define PRE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define PRE_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pre_pkg.sv =====
// shared types, constants and tables of the polyline ribbon expander
`default_nettype none
package pre_pkg;
    localparam int FRAC_BITS = 16;
    localparam int CFG_W = 16;
    localparam int IN_W = 184;
    localparam int OUT_W = 144;

    typedef struct packed {
        logic        first_point;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
        logic [30:0] point_width;
        logic [30:0] start_width;
        logic [7:0]  trail_red;
        logic [7:0]  trail_green;
        logic [7:0]  trail_blue;
    } in_item_t;

    // shared unit operations
    localparam logic [1:0] OP_SQRT = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [65:0] num;
        logic [63:0] den;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [65:0] quo;
    } unit_rsp_t;

    function automatic logic [1:0] corner_of(input logic [2:0] k);
        logic [1:0] c;
        unique case (k)
            3'd0: c = 2'd0;
            3'd1: c = 2'd1;
            3'd2: c = 2'd2;
            3'd3: c = 2'd0;
            3'd4: c = 2'd2;
            default: c = 2'd3;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647) r = 32'h7fffffff;
        else if (v < -34'sd2147483648) r = 32'h80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/pre_iter_unit.sv =====
// shared radix-2 unit: restoring square root or long division, one bit a cycle
`default_nettype none
module pre_iter_unit import pre_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire unit_req_t req,
    output unit_rsp_t      rsp
);
    logic        busy_reg, busy_next;
    logic [1:0]  op_reg, op_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [67:0] rem_reg, rem_next;
    logic [65:0] num_reg, num_next;
    logic [65:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic [67:0] trial;
    logic [67:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        shifted = '0;
        trial = '0;
        rsp.done = 1'b0;
        rsp.quo = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next = req.op;
            num_next = req.num;
            den_next = req.den;
            rem_next = '0;
            quo_next = '0;
            // 66-bit radicand is 33 bit pairs
            cnt_next = (req.op == OP_SQRT) ? 7'd33 : 7'd66;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_SQRT)
            begin
                // two radicand bits in, trial subtracts 4q+1
                shifted = {rem_reg[65:0], num_reg[65:64]};
                trial = shifted - {quo_reg[65:0], 2'b01};
                num_next = {num_reg[63:0], 2'b00};
                if (!trial[67])
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[64:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[64:0], 1'b0};
                end
            end
            else
            begin
                shifted = {rem_reg[66:0], num_reg[65]};
                trial = shifted - {4'd0, den_reg};
                num_next = {num_reg[64:0], 1'b0};
                if (!trial[67])
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[64:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[64:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) busy_next = 1'b0;
        end
        if (busy_reg && cnt_reg == 7'd1) rsp.done = 1'b1;
        if (busy_reg && cnt_reg == 7'd1) rsp.quo = quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            op_reg <= OP_SQRT;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            op_reg <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end
endmodule
`default_nettype wire

// ===== rtl/polyline_ribbon_expander.sv =====
// top level of the polyline ribbon expander: sequencer, point state, vertex output
//
// one point enters as a beat on the s_axis channel; tdata packs from bit 0 up:
// point_x, point_y, point_z, point_width, start_width, red, green, blue;
// s_axis_tuser carries first_point.
// a segment gives six vertex beats on m_axis, the sixth with m_axis_tlast set.
// a trail start gives no beat; a short segment gives no beat and runs only
// the squares, the square root and the threshold compare.
// a drawn segment runs: three squares through the multiplier, a 33-step square
// root, two 66-step divisions for the offset and two for alpha, the root and
// the divisions on one shared bit-serial unit, then corner setup and six
// output beats.
// s_axis_tready is low from acceptance until the cycle after the last vertex beat.
// the output register holds while m_axis_tvalid is high and m_axis_tready is low;
// the sequencer waits, so every stalled cycle lengthens the item.
// reset clears point history and corner reuse; min_segment_length resets to 1.
// cfg_we writes min_segment_length from cfg_data.
`default_nettype none
module polyline_ribbon_expander import pre_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // point_x, point_y, point_z, point_width, start_width, red, green, blue, pad
    input  wire logic [IN_W-1:0]    s_axis_tdata,
    // first_point
    input  wire logic               s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // vertex_x, vertex_y, vertex_z, tex_u, tex_v, red, green, blue, alpha, pad
    output logic [OUT_W-1:0]        m_axis_tdata,
    output logic                    m_axis_tlast
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_SQRT = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_DVX  = 4'd4;
    localparam logic [3:0] S_DVY  = 4'd5;
    localparam logic [3:0] S_DAN  = 4'd6;
    localparam logic [3:0] S_DAF  = 4'd7;
    localparam logic [3:0] S_CRN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_WAIT = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [CFG_W-1:0] minlen_reg;
    logic        have_prev_reg, reuse_reg;
    logic [31:0] prev_pos_reg [3];
    logic [30:0] prev_w_reg;
    logic [31:0] upper_reg [3];
    logic [31:0] lower_reg [3];
    in_item_t    cur_reg;
    logic signed [32:0] d_reg [3];
    logic [1:0]  sqi_reg;
    logic [65:0] sum_reg;
    logic [63:0] prod_reg;
    logic        prod_v_reg;
    logic [33:0] len_reg;
    logic [31:0] mx_reg, my_reg;
    logic [15:0] an_reg, af_reg;
    logic        started_reg;
    logic [31:0] nh_reg [3], nl_reg [3], fh_reg [3], fl_reg [3];
    logic [2:0]  k_reg;
    logic [OUT_W-1:0] tdata_reg;
    logic        tvalid_reg, tlast_reg;

    unit_req_t   req;
    unit_rsp_t   rsp;
    in_item_t    in_item;
    logic [32:0] mag_sel;
    logic [32:0] dmag [3];
    logic signed [33:0] offx, offy;
    logic signed [33:0] prev_ext [3];
    logic signed [33:0] cur_ext [3];
    logic [1:0]  c;
    logic [31:0] vx, vy, vz;

    pre_iter_unit u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign in_item = {s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
        s_axis_tdata[95:64], s_axis_tdata[126:96], s_axis_tdata[157:127],
        s_axis_tdata[165:158], s_axis_tdata[173:166], s_axis_tdata[181:174]};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dmag[i] = d_reg[i][32] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
        mag_sel = dmag[sqi_reg];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            prev_ext[i] = $signed({{2{prev_pos_reg[i][31]}}, prev_pos_reg[i]});
        cur_ext[0] = $signed({{2{cur_reg.point_x[31]}}, cur_reg.point_x});
        cur_ext[1] = $signed({{2{cur_reg.point_y[31]}}, cur_reg.point_y});
        cur_ext[2] = $signed({{2{cur_reg.point_z[31]}}, cur_reg.point_z});
    end

    assign offx = d_reg[1] > 0 ? -$signed({2'b0, mx_reg}) : $signed({2'b0, mx_reg});
    assign offy = d_reg[0] < 0 ? -$signed({2'b0, my_reg}) : $signed({2'b0, my_reg});

    always_comb
    begin
        req.start = started_reg;
        req.op = OP_DIV;
        req.num = '0;
        req.den = 64'd1;
        unique case (state_reg)
            S_SQRT:
            begin
                req.op = OP_SQRT;
                req.num = sum_reg;
            end
            S_DVX:
            begin
                req.num = 66'(dmag[1] * prev_w_reg);
                req.den = {29'd0, len_reg, 1'b0};
            end
            S_DVY:
            begin
                req.num = 66'(dmag[0] * prev_w_reg);
                req.den = {29'd0, len_reg, 1'b0};
            end
            S_DAN:
            begin
                req.num = {27'd0, prev_w_reg, 8'd0};
                req.den = {33'd0, cur_reg.start_width};
            end
            S_DAF:
            begin
                req.num = {27'd0, cur_reg.point_width, 8'd0};
                req.den = {33'd0, cur_reg.start_width};
            end
            default: req.op = OP_DIV;
        endcase
    end

    always_comb
    begin
        c = corner_of(k_reg);
        unique case (c)
            2'd0:
            begin
                vx = nh_reg[0]; vy = nh_reg[1]; vz = nh_reg[2];
            end
            2'd1:
            begin
                vx = fh_reg[0]; vy = fh_reg[1]; vz = fh_reg[2];
            end
            2'd2:
            begin
                vx = fl_reg[0]; vy = fl_reg[1]; vz = fl_reg[2];
            end
            default:
            begin
                vx = nl_reg[0]; vy = nl_reg[1]; vz = nl_reg[2];
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata = tdata_reg;
    assign m_axis_tlast = tlast_reg;

    function automatic logic [15:0] sat_alpha(input logic [65:0] q);
        return (q > 66'd65535) ? 16'hffff : q[15:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            minlen_reg <= 16'd1;
            have_prev_reg <= 1'b0;
            reuse_reg <= 1'b0;
            tvalid_reg <= 1'b0;
            started_reg <= 1'b0;
            prev_w_reg <= '0;
            for (int i = 0; i < 3; i++) prev_pos_reg[i] <= '0;
        end
        else
        begin
            started_reg <= 1'b0;
            if (cfg_we) minlen_reg <= cfg_data;
            if (state_reg == S_OUT && (!tvalid_reg || m_axis_tready))
                tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (in_item.first_point || !have_prev_reg)
                        begin
                            prev_pos_reg[0] <= in_item.point_x;
                            prev_pos_reg[1] <= in_item.point_y;
                            prev_pos_reg[2] <= in_item.point_z;
                            prev_w_reg <= in_item.point_width;
                            have_prev_reg <= 1'b1;
                            reuse_reg <= 1'b0;
                            state_reg <= S_WAIT;
                        end
                        else
                            state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (prod_v_reg && sqi_reg == 2'd2)
                    begin
                        state_reg <= S_SQRT;
                        started_reg <= 1'b1;
                    end
                end
                S_SQRT:
                    if (rsp.done) state_reg <= S_CMP;
                S_CMP:
                begin
                    if (len_reg <= {18'd0, minlen_reg})
                    begin
                        prev_pos_reg[0] <= cur_reg.point_x;
                        prev_pos_reg[1] <= cur_reg.point_y;
                        prev_pos_reg[2] <= cur_reg.point_z;
                        prev_w_reg <= cur_reg.point_width;
                        reuse_reg <= 1'b0;
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_DVX;
                        started_reg <= 1'b1;
                    end
                end
                S_DVX:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_DVY;
                        started_reg <= 1'b1;
                    end
                end
                S_DVY:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_DAN;
                        started_reg <= 1'b1;
                    end
                end
                S_DAN:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_DAF;
                        started_reg <= 1'b1;
                    end
                end
                S_DAF:
                    if (rsp.done) state_reg <= S_CRN;
                S_CRN: state_reg <= S_OUT;
                S_OUT:
                begin
                    if ((!tvalid_reg || m_axis_tready) && k_reg == 3'd5)
                    begin
                        prev_pos_reg[0] <= cur_reg.point_x;
                        prev_pos_reg[1] <= cur_reg.point_y;
                        prev_pos_reg[2] <= cur_reg.point_z;
                        prev_w_reg <= cur_reg.point_width;
                        reuse_reg <= 1'b1;
                        state_reg <= S_WAIT;
                    end
                end
                default:
                    if (!tvalid_reg || m_axis_tready) state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_v_reg <= 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cur_reg <= in_item;
                d_reg[0] <= $signed({in_item.point_x[31], in_item.point_x})
                    - $signed({prev_pos_reg[0][31], prev_pos_reg[0]});
                d_reg[1] <= $signed({in_item.point_y[31], in_item.point_y})
                    - $signed({prev_pos_reg[1][31], prev_pos_reg[1]});
                d_reg[2] <= $signed({in_item.point_z[31], in_item.point_z})
                    - $signed({prev_pos_reg[2][31], prev_pos_reg[2]});
                sqi_reg <= 2'd0;
                sum_reg <= '0;
                k_reg <= 3'd0;
            end
            S_SQ:
            begin
                // one 33x33 square into prod_reg, added to the sum in the next cycle; the next square waits for that
                if (!prod_v_reg)
                begin
                    prod_reg <= 64'(mag_sel * mag_sel);
                    prod_v_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_reg + {2'd0, prod_reg};
                    if (sqi_reg != 2'd2) sqi_reg <= sqi_reg + 2'd1;
                end
            end
            S_SQRT: if (rsp.done) len_reg <= rsp.quo[33:0];
            S_DVX: if (rsp.done) mx_reg <= rsp.quo[31:0];
            S_DVY: if (rsp.done) my_reg <= rsp.quo[31:0];
            S_DAN:
                if (rsp.done)
                    an_reg <= (cur_reg.start_width == '0) ? 16'hffff : sat_alpha(rsp.quo);
            S_DAF:
                if (rsp.done)
                    af_reg <= (cur_reg.start_width == '0) ? 16'hffff : sat_alpha(rsp.quo);
            S_CRN:
            begin
                nh_reg[0] <= reuse_reg ? upper_reg[0] : sat32(prev_ext[0] + offx);
                nl_reg[0] <= reuse_reg ? lower_reg[0] : sat32(prev_ext[0] - offx);
                nh_reg[1] <= reuse_reg ? upper_reg[1] : sat32(prev_ext[1] + offy);
                nl_reg[1] <= reuse_reg ? lower_reg[1] : sat32(prev_ext[1] - offy);
                nh_reg[2] <= reuse_reg ? upper_reg[2] : prev_pos_reg[2];
                nl_reg[2] <= reuse_reg ? lower_reg[2] : prev_pos_reg[2];
                fh_reg[0] <= sat32(cur_ext[0] + offx);
                fl_reg[0] <= sat32(cur_ext[0] - offx);
                fh_reg[1] <= sat32(cur_ext[1] + offy);
                fl_reg[1] <= sat32(cur_ext[1] - offy);
                fh_reg[2] <= cur_reg.point_z;
                fl_reg[2] <= cur_reg.point_z;
            end
            S_OUT:
            begin
                if (!tvalid_reg || m_axis_tready)
                begin
                    tdata_reg <= {6'd0, (c == 2'd0 || c == 2'd3) ? an_reg : af_reg,
                        cur_reg.trail_blue, cur_reg.trail_green, cur_reg.trail_red,
                        (c == 2'd2 || c == 2'd3), (c == 2'd1 || c == 2'd2), vz, vy, vx};
                    tlast_reg <= (k_reg == 3'd5);
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd5)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            upper_reg[i] <= fh_reg[i];
                            lower_reg[i] <= fl_reg[i];
                        end
                    end
                end
            end
            default: k_reg <= k_reg;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/pre_checker.sv =====
// port-level checker for the polyline ribbon expander, bound to the top level
`default_nettype none
`include "polyline_ribbon_expander_defines.svh"
module pre_checker import pre_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tlast
);
    `PRE_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "vertex beat dropped under stall")
    `PRE_ASSERT(a_no_overlap, !(s_axis_tready && m_axis_tvalid && !m_axis_tready && m_axis_tlast == 1'b0), "input taken mid segment")
    `PRE_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready held after accepted point")
    `PRE_ASSERT(a_pad, !m_axis_tvalid || m_axis_tdata[OUT_W-1:OUT_W-6] == 6'd0, "tdata pad bits not zero")
endmodule
bind polyline_ribbon_expander pre_checker u_pre_checker (.*);
`default_nettype wire
